### rtl/fpfr_pkg.sv
// fpfr_pkg: shared types, constants and the color palette of the framed pixel receiver
// no dependencies; imported by fpfr_cell, framed_pixel_frame_receiver and the testbench

package fpfr_pkg;

    // byte and field widths fixed by the interface
    localparam int BYTE_W  = 8;
    localparam int NIBBLE_W = 4;
    localparam int POS_W   = 3;
    localparam int RGB_W   = 24;

    // coordinate counters hold any column or row index up to fifteen
    localparam int COORD_W = 4;

    // frame header
    localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'hAA;

    typedef logic [NIBBLE_W-1:0] nibble_t;
    typedef logic [RGB_W-1:0]    rgb_t;

    // 16-entry palette, red in the top byte
    function automatic rgb_t palette_lookup(input nibble_t idx);
        rgb_t rgb;
        unique case (idx)
            4'd0:    rgb = 24'h000000;
            4'd1:    rgb = 24'hFF0000;
            4'd2:    rgb = 24'h00FF00;
            4'd3:    rgb = 24'h0000FF;
            4'd4:    rgb = 24'hFFFF00;
            4'd5:    rgb = 24'hFF00FF;
            4'd6:    rgb = 24'h00FFFF;
            4'd7:    rgb = 24'hFFFFFF;
            4'd8:    rgb = 24'hFF8000;
            4'd9:    rgb = 24'h008000;
            4'd10:   rgb = 24'h000080;
            4'd11:   rgb = 24'h964B00;
            4'd12:   rgb = 24'hFF69B4;
            4'd13:   rgb = 24'hE0FFFF;
            4'd14:   rgb = 24'hFFB6C1;
            default: rgb = 24'h808080;
        endcase
        return rgb;
    endfunction

endpackage

### rtl/framed_pixel_frame_receiver.sv
// framed_pixel_frame_receiver: header/checksum framed pixel receiver with palette output
// depends on fpfr_pkg and fpfr_cell
//
//  channel | handshake          | word
//  --------+--------------------+---------------------------------------------------
//  in      | in_valid, in_stall | rx_byte
//  out     | out_valid, out_stall | frame_ok, pixel_x, pixel_y, color_index,
//          |                    |   rgb_color, last
//
// a good checksum starts an emit phase of MATRIX_WIDTH * MATRIX_HEIGHT results, one result
// per cycle while out_stall is low, as the cell chain shifts its head into the output
// register; input stalls during that phase.
// a bad checksum gives one error word in the cycle after it is accepted.
// reset clears the frame state and the output valid; the cell chain is not cleared,
// every cell is filled by the frame before it is read.
// out_stall holds the output register; the emit phase pauses while it is held.

module framed_pixel_frame_receiver
    import fpfr_pkg::*;
#(
    parameter int MATRIX_WIDTH  = 8,
    parameter int MATRIX_HEIGHT = 8
)
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                in_valid,
    output logic                in_stall,
    input  logic [BYTE_W-1:0]   rx_byte,

    output logic                out_valid,
    input  logic                out_stall,
    output logic                frame_ok,
    output logic [POS_W-1:0]    pixel_x,
    output logic [POS_W-1:0]    pixel_y,
    output logic [NIBBLE_W-1:0] color_index,
    output logic [RGB_W-1:0]    rgb_color,
    output logic                last
);

    localparam int PIXEL_COUNT = MATRIX_WIDTH * MATRIX_HEIGHT;
    localparam int CNT_W       = $clog2(PIXEL_COUNT + 1);

    localparam logic [CNT_W-1:0]   PIX_END = CNT_W'(PIXEL_COUNT);
    localparam logic [COORD_W-1:0] X_LAST  = COORD_W'(MATRIX_WIDTH - 1);
    localparam logic [COORD_W-1:0] Y_LAST  = COORD_W'(MATRIX_HEIGHT - 1);

    // frame states
    localparam logic [1:0] ST_HUNT = 2'd0;
    localparam logic [1:0] ST_RECV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [CNT_W-1:0]   pos_reg, pos_next;
    logic [BYTE_W-1:0]  xor_reg, xor_next;
    logic [COORD_W-1:0] x_reg, x_next;
    logic [COORD_W-1:0] y_reg, y_next;

    logic               out_valid_reg, out_valid_next;
    logic               ok_reg;
    logic [POS_W-1:0]   px_reg;
    logic [POS_W-1:0]   py_reg;
    nibble_t            ci_reg;
    rgb_t               rgb_reg;
    logic               last_reg;

    logic               in_acc;
    logic               slot_free;
    logic               at_check;
    logic               pix_acc;
    logic               err_load;
    logic               emit_load;
    logic               emit_last;
    logic               chain_shift;
    nibble_t            chain_in;
    nibble_t            chain_head;

    nibble_t            link [PIXEL_COUNT+1];

    // handshake decode
    assign slot_free = !out_valid_reg || !out_stall;
    assign at_check  = (state_reg == ST_RECV) && (pos_reg == PIX_END);
    assign in_stall  = (state_reg == ST_EMIT) || (at_check && !slot_free);
    assign in_acc    = in_valid && !in_stall;
    assign pix_acc   = in_acc && (state_reg == ST_RECV) && (pos_reg != PIX_END);
    assign err_load  = in_acc && at_check && (rx_byte != xor_reg);
    assign emit_load = (state_reg == ST_EMIT) && slot_free;
    assign emit_last = (x_reg == X_LAST) && (y_reg == Y_LAST);

    // cell chain: new pixels enter at the tail, results leave from the head
    assign chain_shift = pix_acc || emit_load;
    assign chain_in    = (state_reg == ST_EMIT) ? '0 : rx_byte[NIBBLE_W-1:0];
    assign link[PIXEL_COUNT] = chain_in;
    assign chain_head  = link[0];

    for (genvar i = 0; i < PIXEL_COUNT; i++)
    begin : g_cell
        fpfr_cell u_cell (
            .clk      (clk),
            .shift    (chain_shift),
            .data_in  (link[i+1]),
            .data_out (link[i])
        );
    end

    // frame control
    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        xor_next   = xor_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        unique case (state_reg)
            ST_HUNT:
            begin
                if (in_acc && (rx_byte == HEADER_BYTE))
                begin
                    state_next = ST_RECV;
                    pos_next   = '0;
                    xor_next   = '0;
                end
            end
            ST_RECV:
            begin
                if (pix_acc)
                begin
                    pos_next = pos_reg + CNT_W'(1);
                    xor_next = xor_reg ^ rx_byte;
                end
                else if (in_acc)
                begin
                    pos_next   = '0;
                    x_next     = '0;
                    y_next     = '0;
                    state_next = (rx_byte == xor_reg) ? ST_EMIT : ST_HUNT;
                end
            end
            ST_EMIT:
            begin
                if (emit_load)
                begin
                    if (emit_last)
                    begin
                        state_next = ST_HUNT;
                    end
                    else if (x_reg == X_LAST)
                    begin
                        x_next = '0;
                        y_next = y_reg + COORD_W'(1);
                    end
                    else
                    begin
                        x_next = x_reg + COORD_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HUNT;
            pos_reg   <= '0;
            xor_reg   <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            xor_reg   <= xor_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
        end
    end

    // output register valid
    always_comb
    begin
        priority if (err_load || emit_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // output word payload
    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            ok_reg   <= 1'b1;
            px_reg   <= x_reg[POS_W-1:0];
            py_reg   <= y_reg[POS_W-1:0];
            ci_reg   <= chain_head;
            rgb_reg  <= palette_lookup(chain_head);
            last_reg <= emit_last;
        end
        else if (err_load)
        begin
            ok_reg   <= 1'b0;
            px_reg   <= '0;
            py_reg   <= '0;
            ci_reg   <= '0;
            rgb_reg  <= '0;
            last_reg <= 1'b1;
        end
    end

    assign out_valid   = out_valid_reg;
    assign frame_ok    = ok_reg;
    assign pixel_x     = px_reg;
    assign pixel_y     = py_reg;
    assign color_index = ci_reg;
    assign rgb_color   = rgb_reg;
    assign last        = last_reg;

    // checks

    // an error word is a lone, all-zero final word
    a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !frame_ok) |-> (last && pixel_x == '0 && pixel_y == '0
            && color_index == '0 && rgb_color == '0))
        else $error("error word is not a zero final word");

    // a taken pixel word that is not final is followed at once by the next one
    a_emit_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && frame_ok && !last) |=> out_valid)
        else $error("gap inside a pixel burst");

    // receive counter never runs past the checksum position
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= PIX_END)
        else $error("byte position past frame end");

    // the emit phase is never left before the final pixel
    a_no_take_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && !emit_last) |=> (state_reg == ST_EMIT || !$past(emit_load)))
        else $error("emit phase left before the final pixel");

endmodule

### rtl/fpfr_cell.sv
// fpfr_cell: one storage cell of the pixel chain, holds one color index
// depends on fpfr_pkg for the nibble type

module fpfr_cell
    import fpfr_pkg::*;
(
    input  logic    clk,
    input  logic    shift,
    input  nibble_t data_in,
    output nibble_t data_out
);

    nibble_t data_reg;

    // take the neighbor's nibble on every shift
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            data_reg <= data_in;
        end
    end

    assign data_out = data_reg;

endmodule

### test/tb_framed_pixel_frame_receiver.sv
// testbench for framed_pixel_frame_receiver: directed frames from a table, then random frames
// depends on fpfr_pkg and the receiver rtl; self-checking against a behavioral decoder
`timescale 1ns / 100ps

module tb_framed_pixel_frame_receiver;
    import fpfr_pkg::*;

    localparam int COLS        = 8;
    localparam int ROWS        = 8;
    localparam int PIXELS      = COLS * ROWS;
    localparam int DIRECTED_ROWS = 5;
    localparam int RANDOM_WORDS = 120;
    localparam int QUIET_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 80;
    localparam int REPORT_MAX  = 10;

    // one output word
    typedef struct packed {
        logic                ok;
        logic [POS_W-1:0]    x;
        logic [POS_W-1:0]    y;
        logic [NIBBLE_W-1:0] ci;
        logic [RGB_W-1:0]    rgb;
        logic                last;
    } pix_word_t;

    // how the pixel bytes of a frame are made
    typedef enum logic [2:0] {
        FILL_RAMP,
        FILL_HEADER,
        FILL_ONES,
        FILL_ZERO,
        FILL_FIRST_HDR,
        FILL_RANDOM
    } fill_mode_t;

    // how the checksum byte is made
    typedef enum logic [1:0] {
        SUM_GOOD,
        SUM_FIXED,
        SUM_FLIP
    } sum_mode_t;

    typedef struct packed {
        logic              has_lead;
        logic [BYTE_W-1:0] lead_byte;
        fill_mode_t        fill;
        sum_mode_t         sum;
        logic [BYTE_W-1:0] sum_byte;
        logic              typed_err;
    } frame_row_t;

    localparam pix_word_t ERROR_WORD = '{1'b0, 3'd0, 3'd0, 4'd0, 24'd0, 1'b1};

    localparam logic [RGB_W-1:0] SHADES [16] = '{
        24'h000000, 24'hFF0000, 24'h00FF00, 24'h0000FF,
        24'hFFFF00, 24'hFF00FF, 24'h00FFFF, 24'hFFFFFF,
        24'hFF8000, 24'h008000, 24'h000080, 24'h964B00,
        24'hFF69B4, 24'hE0FFFF, 24'hFFB6C1, 24'h808080
    };

    // directed frames: stray bytes, header bytes inside a frame, extremes, bad checksums
    localparam frame_row_t DIRECTED_FRAMES [DIRECTED_ROWS] = '{
        '{1'b1, 8'h00, FILL_RAMP,      SUM_GOOD,  8'h00, 1'b0},
        '{1'b1, 8'hFF, FILL_HEADER,    SUM_GOOD,  8'h00, 1'b0},
        '{1'b1, 8'h55, FILL_ONES,      SUM_FIXED, 8'hFF, 1'b1},
        '{1'b0, 8'h00, FILL_ZERO,      SUM_FIXED, 8'hAA, 1'b1},
        '{1'b1, 8'hAB, FILL_FIRST_HDR, SUM_GOOD,  8'h00, 1'b0}
    };

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [BYTE_W-1:0]   rx_byte;
    logic                out_valid;
    logic                out_stall;
    logic                frame_ok;
    logic [POS_W-1:0]    pixel_x;
    logic [POS_W-1:0]    pixel_y;
    logic [NIBBLE_W-1:0] color_index;
    logic [RGB_W-1:0]    rgb_color;
    logic                last;

    framed_pixel_frame_receiver #(
        .MATRIX_WIDTH  (COLS),
        .MATRIX_HEIGHT (ROWS)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .frame_ok    (frame_ok),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .color_index (color_index),
        .rgb_color   (rgb_color),
        .last        (last)
    );

    // decoder state mirrored from the byte stream
    logic              trk_open;
    int                trk_pos;
    logic [BYTE_W-1:0] trk_xor;
    logic [3:0]        trk_store [PIXELS];

    pix_word_t pixel_words_due [$];
    int        mismatches;
    int        words_sent;
    int        quiet_cycles;
    int        idle_pct;
    int        stall_pct;
    bit        calm;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // advance the decoder by one accepted byte, queue the words it yields
    function automatic int decode_rx_byte(input logic [BYTE_W-1:0] b);
        pix_word_t w;
        int        i;
        if (!trk_open)
        begin
            if (b == HEADER_BYTE)
            begin
                trk_open = 1'b1;
                trk_pos  = 0;
                trk_xor  = '0;
            end
            return 0;
        end
        if (trk_pos < PIXELS)
        begin
            trk_store[trk_pos] = b[3:0];
            trk_xor            = trk_xor ^ b;
            trk_pos++;
            return 0;
        end
        // checksum byte closes the frame
        trk_open = 1'b0;
        trk_pos  = 0;
        if (b != trk_xor)
        begin
            w      = '0;
            w.last = 1'b1;
            pixel_words_due.push_back(w);
            return 1;
        end
        for (i = 0; i < PIXELS; i++)
        begin
            w.ok   = 1'b1;
            w.x    = POS_W'(i % COLS);
            w.y    = POS_W'(i / COLS);
            w.ci   = trk_store[i];
            w.rgb  = SHADES[trk_store[i]];
            w.last = (i == PIXELS - 1);
            pixel_words_due.push_back(w);
        end
        return PIXELS;
    endfunction

    function automatic logic [BYTE_W-1:0] noise_byte();
        logic [BYTE_W-1:0] b;
        do
            b = BYTE_W'($urandom_range(0, 255));
        while (b == HEADER_BYTE);
        return b;
    endfunction

    function automatic logic [BYTE_W-1:0] fill_byte(input fill_mode_t mode, input int i);
        case (mode)
            FILL_RAMP:      return BYTE_W'(i * 37 + 3);
            FILL_HEADER:    return HEADER_BYTE;
            FILL_ONES:      return 8'hFF;
            FILL_ZERO:      return 8'h00;
            FILL_FIRST_HDR: return (i == 0) ? HEADER_BYTE : 8'h00;
            default:        return ($urandom_range(0, 7) == 0) ? HEADER_BYTE
                                                               : BYTE_W'($urandom());
        endcase
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 15;
            default: return 50;
        endcase
    endfunction

    // push one byte through the input channel; a typed error replaces the decoded words
    task automatic send_word(input logic [BYTE_W-1:0] b, input bit typed_err);
        int n;
        if (!calm && $urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
        n = decode_rx_byte(b);
        if (typed_err)
        begin
            repeat (n) void'(pixel_words_due.pop_back());
            pixel_words_due.push_back(ERROR_WORD);
        end
    endtask

    task automatic send_frame(input frame_row_t r);
        logic [BYTE_W-1:0] px;
        logic [BYTE_W-1:0] sum;
        int                i;
        if (r.has_lead)
            send_word(r.lead_byte, 1'b0);
        send_word(HEADER_BYTE, 1'b0);
        sum = '0;
        for (i = 0; i < PIXELS; i++)
        begin
            px  = fill_byte(r.fill, i);
            sum = sum ^ px;
            send_word(px, 1'b0);
        end
        case (r.sum)
            SUM_GOOD:  send_word(sum, r.typed_err);
            SUM_FLIP:  send_word(sum ^ BYTE_W'(1 << $urandom_range(0, 7)), r.typed_err);
            default:   send_word(r.sum_byte, r.typed_err);
        endcase
    endtask

    // output stall in random bursts
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            if (!calm && $urandom_range(0, 99) < stall_pct)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
        end
    end

    // compare each accepted output word with the oldest expected one
    always @(posedge clk)
    begin
        pix_word_t got;
        pix_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{frame_ok, pixel_x, pixel_y, color_index, rgb_color, last};
            if (pixel_words_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected word: ok=%0d x=%0d y=%0d ci=%0d rgb=%h last=%0d",
                             got.ok, got.x, got.y, got.ci, got.rgb, got.last);
            end
            else
            begin
                want = pixel_words_due.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display({"mismatch: exp ok=%0d x=%0d y=%0d ci=%0d rgb=%h last=%0d,",
                                  " got ok=%0d x=%0d y=%0d ci=%0d rgb=%h last=%0d"},
                                 want.ok, want.x, want.y, want.ci, want.rgb, want.last,
                                 got.ok, got.x, got.y, got.ci, got.rgb, got.last);
                end
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        frame_row_t row;
        int         n;
        int         start;
        trk_open     = 1'b0;
        trk_pos      = 0;
        trk_xor      = '0;
        mismatches   = 0;
        words_sent   = 0;
        quiet_cycles = 0;
        calm         = 1'b0;
        idle_pct     = 20;
        stall_pct    = 20;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        rx_byte  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed frames
        for (n = 0; n < DIRECTED_ROWS; n++)
            send_frame(DIRECTED_FRAMES[n]);

        // random frames with stray bytes between them; the tail runs without idling or output stalls
        start = words_sent;
        while (words_sent - start < RANDOM_WORDS)
        begin
            calm      = (words_sent - start) > RANDOM_WORDS - 80;
            idle_pct  = pick_pct();
            stall_pct = pick_pct();
            repeat ($urandom_range(0, 4)) send_word(noise_byte(), 1'b0);
            row           = '0;
            row.fill      = FILL_RANDOM;
            row.sum       = ($urandom_range(0, 4) == 0) ? SUM_FLIP : SUM_GOOD;
            send_frame(row);
        end
        in_valid <= 1'b0;

        // drain
        while (pixel_words_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pixel_words_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### sim.f
rtl/fpfr_pkg.sv
rtl/fpfr_cell.sv
rtl/framed_pixel_frame_receiver.sv
test/tb_framed_pixel_frame_receiver.sv
